// ===== hw/rtl/pwm_with_day_clock_core_assert.svh =====
// ----------------------------------------------------------------------------
// PWM with day clock: assertion macros
// Concurrent assertion wrappers for the core, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef PWM_WITH_DAY_CLOCK_CORE_ASSERT_SVH
`define PWM_WITH_DAY_CLOCK_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PWDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PWDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PWDC_ASSERT(lbl, prop, msg)
`define PWDC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pwdc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM with day clock: package
// Shared types and constants of the core.
// ----------------------------------------------------------------------------
package pwdc_pkg;

    localparam logic [7:0] BYTE_UP   = 8'h71;
    localparam logic [7:0] BYTE_DOWN = 8'h61;

    localparam logic [9:0]  PWM_TOP_RESET     = 10'd1001;
    localparam logic [15:0] TICK_DIVIDE_RESET = 16'd50000;
    localparam logic [9:0]  DUTY_LOW_RESET    = 10'd55;
    localparam logic [9:0]  DUTY_HIGH_RESET   = 10'd95;
    localparam logic [9:0]  DUTY_RESET        = 10'd75;
    localparam logic [9:0]  DUTY_MAX          = 10'd1023;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PWM_TOP     = 2'd0,
        REG_TICK_DIVIDE = 2'd1,
        REG_DUTY_LOW    = 2'd2,
        REG_DUTY_HIGH   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [9:0]  pwm_top;
        logic [15:0] tick_divide;
        logic [9:0]  duty_low;
        logic [9:0]  duty_high;
    } cfg_t;

    // Per-cycle update strobes derived from the item being retired.
    typedef struct packed {
        logic tick_en;
        logic duty_up;
        logic duty_down;
    } item_ctl_t;

endpackage

// ===== hw/rtl/pwdc_pwm.sv =====
// ----------------------------------------------------------------------------
// PWM with day clock: PWM generator
// PWM counter, output level and duty value with guarded up/down steps.
// ----------------------------------------------------------------------------
module pwdc_pwm
(
    input  logic               clk,
    input  logic               rst_n,
    input  pwdc_pkg::cfg_t     cfg,
    input  pwdc_pkg::item_ctl_t ctl,
    output logic               pwm_level,
    output logic [9:0]         duty_value
);
    import pwdc_pkg::*;

    logic [9:0] count_reg, count_next;
    logic       level_reg, level_next;
    logic [9:0] duty_reg, duty_next;

    always_comb
    begin
        count_next = count_reg;
        level_next = level_reg;
        duty_next  = duty_reg;
        if (ctl.tick_en)
        begin
            if (count_reg < cfg.pwm_top)
            begin
                level_next = (count_reg < duty_reg);
                count_next = count_reg + 10'd1;
            end
            else
            begin
                count_next = '0;
            end
        end
        if (ctl.duty_up && (duty_reg < cfg.duty_high) && (duty_reg != DUTY_MAX))
        begin
            duty_next = duty_reg + 10'd1;
        end
        else if (ctl.duty_down && (duty_reg > cfg.duty_low) && (duty_reg != '0))
        begin
            duty_next = duty_reg - 10'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
            duty_reg  <= DUTY_RESET;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= level_next;
            duty_reg  <= duty_next;
        end
    end

    assign pwm_level  = level_reg;
    assign duty_value = duty_reg;

endmodule

// ===== hw/rtl/pwdc_clock.sv =====
// ----------------------------------------------------------------------------
// PWM with day clock: day clock
// Tick prescaler driving a seconds, minutes, hours and days cascade.
// ----------------------------------------------------------------------------
module pwdc_clock
(
    input  logic                clk,
    input  logic                rst_n,
    input  pwdc_pkg::cfg_t      cfg,
    input  pwdc_pkg::item_ctl_t ctl,
    output logic [5:0]          seconds,
    output logic [5:0]          minutes,
    output logic [4:0]          hours,
    output logic [7:0]          days
);
    import pwdc_pkg::*;

    logic [15:0] presc_reg, presc_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [7:0]  day_reg, day_next;

    always_comb
    begin
        presc_next = presc_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        if (ctl.tick_en)
        begin
            // The prescaler fires on an exact match, so a count left above a
            // lowered terminal value wraps through zero before firing.
            if (presc_reg == cfg.tick_divide)
            begin
                presc_next = '0;
                if (sec_reg < SEC_LAST)
                begin
                    sec_next = sec_reg + 6'd1;
                end
                else
                begin
                    sec_next = '0;
                    if (min_reg < MIN_LAST)
                    begin
                        min_next = min_reg + 6'd1;
                    end
                    else
                    begin
                        min_next = '0;
                        if (hour_reg < HOUR_LAST)
                        begin
                            hour_next = hour_reg + 5'd1;
                        end
                        else
                        begin
                            hour_next = '0;
                            day_next  = day_reg + 8'd1;
                        end
                    end
                end
            end
            else
            begin
                presc_next = presc_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_reg <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            day_reg   <= '0;
        end
        else
        begin
            presc_reg <= presc_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            day_reg   <= day_next;
        end
    end

    assign seconds = sec_reg;
    assign minutes = min_reg;
    assign hours   = hour_reg;
    assign days    = day_reg;

endmodule

// ===== hw/rtl/pwm_with_day_clock_core.sv =====
// ----------------------------------------------------------------------------
// PWM with day clock: top level
// Item-driven PWM generator with a seconds to days real-time clock.
// ----------------------------------------------------------------------------
// Each input item is either a timer tick (kind 0) or a received serial byte
// (kind 1). A byte 0x71 raises the duty and 0x61 lowers it, within the limits
// held in the duty_low and duty_high registers. A tick steps the PWM counter
// and the prescaler that feeds the day clock.
// Every accepted item gives exactly one result item carrying the PWM level,
// the duty and the clock fields as they stand after that item.
// Both channels use valid and stall; an item moves on a rising edge where
// valid is high and stall is low.
// An accepted item sits in the input register, then retires into the state
// registers, whose new values are the result. Throughput is one item per
// cycle while the receiver does not stall, set by the update of the PWM and
// clock state as each item retires.
// While the receiver stalls, the result is held and one further item may wait
// in the input register; after that, in_stall is raised.
// Reset (rst_n low, asynchronous) clears the pipeline, sets the duty to 75,
// the clock to zero and the registers to their documented defaults.
// Configuration is written through cfg_we, cfg_index and cfg_data; write it
// only while the core is idle, which the core itself does not enforce.
// ----------------------------------------------------------------------------
module pwm_with_day_clock_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pwm_out,
    output logic [9:0]                          duty,
    output logic [5:0]                          seconds,
    output logic [5:0]                          minutes,
    output logic [4:0]                          hours,
    output logic [7:0]                          days,
    input  logic                                cfg_we,
    input  logic [pwdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pwdc_pkg::*;

`include "pwm_with_day_clock_core_assert.svh"

    cfg_t       cfg_reg, cfg_next;
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_kind_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_accept;
    logic       advance;
    item_ctl_t  ctl;

    // The state registers of the PWM and clock units double as the result
    // register: they only change when an item retires into an empty or
    // draining output slot, so a stalled result holds by construction.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = in_accept || (s1_valid_reg && !advance);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_comb
    begin
        ctl.tick_en   = advance && !s1_kind_reg;
        ctl.duty_up   = advance && s1_kind_reg && (s1_byte_reg == BYTE_UP);
        ctl.duty_down = advance && s1_kind_reg && (s1_byte_reg == BYTE_DOWN);
    end

    // Configuration writes; bits above a register's width are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_PWM_TOP:     cfg_next.pwm_top     = cfg_data[9:0];
                REG_TICK_DIVIDE: cfg_next.tick_divide = cfg_data[15:0];
                REG_DUTY_LOW:    cfg_next.duty_low    = cfg_data[9:0];
                REG_DUTY_HIGH:   cfg_next.duty_high   = cfg_data[9:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_top     <= PWM_TOP_RESET;
            cfg_reg.tick_divide <= TICK_DIVIDE_RESET;
            cfg_reg.duty_low    <= DUTY_LOW_RESET;
            cfg_reg.duty_high   <= DUTY_HIGH_RESET;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_byte_reg <= rx_byte;
        end
    end

    pwdc_pwm u_pwm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ctl        (ctl),
        .pwm_level  (pwm_out),
        .duty_value (duty)
    );

    pwdc_clock u_clock
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctl     (ctl),
        .seconds (seconds),
        .minutes (minutes),
        .hours   (hours),
        .days    (days)
    );

    assign out_valid = out_valid_reg;

    // The clock cascade never leaves its legal ranges.
    `PWDC_ASSERT(a_clock_range, (seconds <= SEC_LAST) && (minutes <= MIN_LAST) && (hours <= HOUR_LAST), "clock field out of range")

    // A retiring byte item leaves the clock and the PWM level untouched.
    `PWDC_ASSERT_NEXT(a_byte_keeps_clock, advance && s1_kind_reg, $stable(seconds) && $stable(pwm_out), "byte item changed clock or level")

    // The duty moves by at most one step per cycle.
    `PWDC_ASSERT(a_duty_step, (duty == $past(duty)) || (duty == 10'($past(duty) + 10'd1)) || (duty == 10'($past(duty) - 10'd1)), "duty jumped")

    // A new result appears only when an item retires.
    `PWDC_ASSERT_NEXT(a_result_source, !advance && !(out_valid_reg && out_stall), !out_valid, "result without an item")

endmodule

// ===== dv/pwdc_reading_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM with day clock: result checker
// Follows the register writes and accepted input items, keeps its own copy of
// the PWM and clock state, and compares every result item field by field.
// ----------------------------------------------------------------------------
module pwdc_reading_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                kind,
    input  logic [7:0]                          rx_byte,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                pwm_out,
    input  logic [9:0]                          duty,
    input  logic [5:0]                          seconds,
    input  logic [5:0]                          minutes,
    input  logic [4:0]                          hours,
    input  logic [7:0]                          days,
    input  logic                                cfg_we,
    input  logic [pwdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int unsigned                         fail_count,
    output int unsigned                         outstanding
);

    import pwdc_pkg::*;

    typedef struct packed {
        logic       pwm_out;
        logic [9:0] duty;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [7:0] days;
    } reading_t;

    cfg_t        regs;
    logic [9:0]  pwm_count;
    logic        pwm_level;
    logic [9:0]  duty_value;
    logic [15:0] prescale;
    logic [5:0]  sec_count;
    logic [5:0]  min_count;
    logic [4:0]  hour_count;
    logic [7:0]  day_count;
    reading_t    expected_readings[$];
    int unsigned mismatches;

    function automatic reading_t predict_reading(input logic is_byte, input logic [7:0] b);
        if (is_byte)
        begin
            if (b == BYTE_UP && duty_value < regs.duty_high && duty_value < DUTY_MAX)
            begin
                duty_value = duty_value + 10'd1;
            end
            else if (b == BYTE_DOWN && duty_value > regs.duty_low && duty_value != 10'd0)
            begin
                duty_value = duty_value - 10'd1;
            end
        end
        else
        begin
            if (pwm_count < regs.pwm_top)
            begin
                pwm_level = (pwm_count < duty_value);
                pwm_count = pwm_count + 10'd1;
            end
            else
            begin
                pwm_count = '0;
            end

            // The prescaler only fires on equality, so after the terminal count
            // is lowered beneath it, it runs on through zero first.
            if (prescale == regs.tick_divide)
            begin
                prescale = '0;
                if (sec_count < SEC_LAST)
                begin
                    sec_count = sec_count + 6'd1;
                end
                else
                begin
                    sec_count = '0;
                    if (min_count < MIN_LAST)
                    begin
                        min_count = min_count + 6'd1;
                    end
                    else
                    begin
                        min_count = '0;
                        if (hour_count < HOUR_LAST)
                        begin
                            hour_count = hour_count + 5'd1;
                        end
                        else
                        begin
                            hour_count = '0;
                            day_count  = day_count + 8'd1;
                        end
                    end
                end
            end
            else
            begin
                prescale = prescale + 16'd1;
            end
        end
        return {pwm_level, duty_value, sec_count, min_count, hour_count, day_count};
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t got;
        reading_t want;
        if (!rst_n)
        begin
            regs.pwm_top     = PWM_TOP_RESET;
            regs.tick_divide = TICK_DIVIDE_RESET;
            regs.duty_low    = DUTY_LOW_RESET;
            regs.duty_high   = DUTY_HIGH_RESET;
            pwm_count  = '0;
            pwm_level  = 1'b0;
            duty_value = DUTY_RESET;
            prescale   = '0;
            sec_count  = '0;
            min_count  = '0;
            hour_count = '0;
            day_count  = '0;
            expected_readings.delete();
            mismatches = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PWM_TOP:     regs.pwm_top     = cfg_data[9:0];
                    REG_TICK_DIVIDE: regs.tick_divide = cfg_data[15:0];
                    REG_DUTY_LOW:    regs.duty_low    = cfg_data[9:0];
                    REG_DUTY_HIGH:   regs.duty_high   = cfg_data[9:0];
                    default:         ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got = {pwm_out, duty, seconds, minutes, hours, days};
                if (expected_readings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with none expected, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("pwm_out", want.pwm_out, got.pwm_out);
                    check_field("duty", want.duty, got.duty);
                    check_field("seconds", want.seconds, got.seconds);
                    check_field("minutes", want.minutes, got.minutes);
                    check_field("hours", want.hours, got.hours);
                    check_field("days", want.days, got.days);
                end
            end

            if (in_valid && !in_stall)
            begin
                expected_readings.push_back(predict_reading(kind, rx_byte));
            end

            outstanding <= expected_readings.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ===== dv/tb_pwm_with_day_clock_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM with day clock: testbench top
// Drives timer ticks and serial bytes into the core under random idling on
// both channels, reprogrammes the registers between phases, and leaves the
// checking to a checker that predicts every result item.
// ----------------------------------------------------------------------------
module tb_pwm_with_day_clock_core;

    import pwdc_pkg::*;

    // Cycles without any item moving on either channel before the run is
    // declared hung. The slowest legitimate gap is a full sender pause plus a
    // full receiver stall plus the pipeline, or a register programming pause;
    // both stay well under the limit.
    localparam int unsigned QUIET_LIMIT = 400;

    localparam int unsigned RANDOM_PHASES = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  kind      = 1'b0;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  pwm_out;
    logic [9:0]            duty;
    logic [5:0]            seconds;
    logic [5:0]            minutes;
    logic [4:0]            hours;
    logic [7:0]            days;
    logic                  cfg_we    = 1'b0;
    cfg_index_t            cfg_index = REG_PWM_TOP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned fail_count;
    int unsigned outstanding;

    // Longest pause each side may draw per item; zero switches idling off.
    int unsigned src_idle_max = 13;
    int unsigned snk_idle_max = 13;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;

    pwm_with_day_clock_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pwm_out   (pwm_out),
        .duty      (duty),
        .seconds   (seconds),
        .minutes   (minutes),
        .hours     (hours),
        .days      (days),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwdc_reading_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pwm_out     (pwm_out),
        .duty        (duty),
        .seconds     (seconds),
        .minutes     (minutes),
        .hours       (hours),
        .days        (days),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // At least a third of the draws give no pause at all, so that runs of back-to-back
    // items occur even in the phases with idling switched on.
    function automatic int unsigned draw_idle(input int unsigned ceiling);
        if (ceiling == 0 || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, ceiling);
    endfunction

    // The 10-bit registers must ignore the upper bits of the write data, so
    // those bits are filled with noise.
    function automatic logic [15:0] with_noise(input logic [9:0] value);
        logic [5:0] noise;
        noise = 6'($urandom_range(0, 63));
        return {noise, value};
    endfunction

    // Receiver: after each result item it draws a stall length and holds
    // stall high for that many cycles, whether or not a result is waiting.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                stall_left = draw_idle(snk_idle_max);
                out_stall <= (stall_left != 0);
            end
            else if (out_stall)
            begin
                stall_left = stall_left - 1;
                if (stall_left == 0)
                begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog: ends a hung run. It is cleared by any item moving.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item and returns in the time step in which it was accepted,
    // with valid still high. The next call then either keeps valid up with a
    // new payload or lowers it for its pause, so valid gets a single update
    // per time step.
    task automatic send_item(input logic is_byte, input logic [7:0] payload);
        int unsigned gap;
        gap = draw_idle(src_idle_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= is_byte;
        rx_byte  <= payload;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Lowers valid and waits until every predicted result item has been
    // received, then lets the pipeline run empty with some margin.
    // The outstanding count is registered in the checker, so it is first
    // read at the edge after the last acceptance.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges; only called while idle.
    task automatic program_regs(input logic [15:0] top_data, input logic [15:0] div_data,
                                input logic [15:0] low_data, input logic [15:0] high_data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PWM_TOP;
        cfg_data  <= top_data;
        @(posedge clk);
        cfg_index <= REG_TICK_DIVIDE;
        cfg_data  <= div_data;
        @(posedge clk);
        cfg_index <= REG_DUTY_LOW;
        cfg_data  <= low_data;
        @(posedge clk);
        cfg_index <= REG_DUTY_HIGH;
        cfg_data  <= high_data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random items with a bias towards the two duty commands. Bytes other than
    // the commands are sent as noise but do not count towards the total, as
    // the core does nothing with them.
    task automatic send_random(input int unsigned count, input int unsigned byte_pct,
                               input int unsigned up_pct, input int unsigned down_pct);
        int unsigned done;
        int unsigned roll;
        logic        is_byte;
        logic [7:0]  payload;
        done = 0;
        while (done < count)
        begin
            is_byte = ($urandom_range(0, 99) < byte_pct);
            payload = 8'($urandom_range(0, 255));
            if (is_byte)
            begin
                roll = $urandom_range(0, 99);
                if (roll < up_pct)
                begin
                    payload = BYTE_UP;
                end
                else if (roll < up_pct + down_pct)
                begin
                    payload = BYTE_DOWN;
                end
            end
            if (!is_byte || payload == BYTE_UP || payload == BYTE_DOWN)
            begin
                done++;
            end
            send_item(is_byte, payload);
        end
    endtask

    initial
    begin
        logic [15:0] top_data;
        logic [15:0] div_data;
        logic [15:0] low_data;
        logic [15:0] high_data;
        int unsigned count;
        int unsigned byte_pct;
        int unsigned up_pct;
        int unsigned down_pct;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings. Ticks carry arbitrary bytes, which must be ignored,
        // and the command bytes are surrounded by their neighbouring codes,
        // which must change nothing. The first tick sets the output high as
        // the counter starts below the reset duty.
        send_item(1'b0, 8'hFF);
        send_item(1'b0, BYTE_UP);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, BYTE_UP);
        send_item(1'b1, BYTE_DOWN);
        send_item(1'b1, 8'h70);
        send_item(1'b1, 8'h72);
        send_item(1'b1, 8'h60);
        send_item(1'b1, 8'h62);
        send_item(1'b0, 8'h00);
        settle();

        // A top of zero (upper data bits set, all to be dropped): every tick
        // clears the counter and the level holds. The terminal count of zero
        // now lies beneath the running prescaler, which must keep counting.
        // The duty lies outside both limits, so neither command may move it.
        program_regs(16'hFC00, 16'h0000, 16'hFFFF, 16'hFC00);
        send_item(1'b1, BYTE_UP);
        send_item(1'b1, BYTE_DOWN);
        send_item(1'b0, 8'h55);
        send_item(1'b0, 8'hAA);
        send_item(1'b0, 8'h0F);
        settle();

        // The smallest non-zero top and the largest terminal count, with both
        // duty limits equal to the duty so that it is pinned.
        program_regs(16'hFC01, 16'hFFFF, with_noise(10'd75), with_noise(10'd75));
        send_item(1'b1, BYTE_UP);
        send_item(1'b1, BYTE_DOWN);
        send_item(1'b0, 8'hF0);
        send_item(1'b0, 8'h33);
        send_item(1'b0, 8'hCC);
        settle();

        // Random phases. The first drives the duty down to zero and tries to
        // push it further; the second brings it back up against a low ceiling;
        // the rest draw their settings, extremes included, at random.
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            src_idle_max = (phase % 3 == 1) ? 0 : 13;
            snk_idle_max = (phase % 3 == 2) ? 0 : 13;
            count    = 40;
            byte_pct = 50;
            up_pct   = 35;
            down_pct = 35;
            if (phase == 0)
            begin
                top_data  = with_noise(10'd1023);
                div_data  = 16'hFFFF;
                low_data  = with_noise(10'd0);
                high_data = with_noise(10'd1023);
                count     = 120;
                byte_pct  = 85;
                up_pct    = 5;
                down_pct  = 90;
            end
            else if (phase == 1)
            begin
                top_data  = with_noise(10'd12);
                div_data  = 16'h0000;
                low_data  = with_noise(10'd0);
                high_data = with_noise(10'd6);
                byte_pct  = 60;
                up_pct    = 80;
                down_pct  = 10;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       top_data = with_noise(10'd1);
                    1:       top_data = with_noise(10'($urandom_range(2, 12)));
                    2:       top_data = with_noise(10'($urandom_range(0, 1023)));
                    default: top_data = with_noise(10'd0);
                endcase
                case ($urandom_range(0, 4))
                    0:       div_data = 16'h0000;
                    1:       div_data = 16'h0001;
                    2:       div_data = 16'($urandom_range(2, 8));
                    3:       div_data = 16'hFFFF;
                    default: div_data = 16'($urandom_range(0, 65535));
                endcase
                // Limits mostly close to the small duties left by the earlier
                // phases, now and then anywhere in the range.
                if ($urandom_range(0, 3) == 0)
                begin
                    low_data  = with_noise(10'($urandom_range(0, 1023)));
                    high_data = with_noise(10'($urandom_range(0, 1023)));
                end
                else
                begin
                    low_data  = with_noise(10'($urandom_range(0, 8)));
                    high_data = with_noise(10'($urandom_range(0, 12)));
                end
            end
            program_regs(top_data, div_data, low_data, high_data);
            send_random(count, byte_pct, up_pct, down_pct);
            settle();
        end

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pwdc_pkg.sv
hw/rtl/pwdc_pwm.sv
hw/rtl/pwdc_clock.sv
hw/rtl/pwm_with_day_clock_core.sv
dv/pwdc_reading_checker.sv
dv/tb_pwm_with_day_clock_core.sv
